@@ src/cht_pkg.sv @@
// cht_pkg: shared constants and the elaboration-time arctangent table
// for the clock_hands_to_time block; depends on nothing
package cht_pkg;

  localparam int IN_W      = 12;  // pixel coordinate port width
  localparam int HOUR_W    = 4;
  localparam int MINUTE_W  = 6;
  localparam int ANG_Q     = 40;  // internal radian and preshift scale
  localparam int XY_W      = 44;  // cordic x/y datapath width
  localparam int INT_DEG_W = 10;  // integer degree bits of an angle, sign included

  localparam int DEF_COORD_BITS   = 12;
  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_CORDIC_STEPS = 20;

  // restoring division, used only while the table is built at elaboration
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = q << 1;
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q40 radians, i >= 1
  function automatic longint atan_pow2(input int i);
    longint sum;
    longint t;
    int     e;
    sum = 0;
    for (int k = 0; k <= ANG_Q; k++) begin
      e = i * (2 * k + 1);
      if (e <= ANG_Q) begin
        t = longint'(udiv(64'd1 << (ANG_Q - e), longint'(2 * k + 1)));
        sum = (k % 2 == 1) ? sum - t : sum + t;
      end
    end
    return sum;
  endfunction

  // atan(1/3) in q40 radians
  function automatic longint atan_third();
    longint sum;
    longint p;
    longint t;
    int     k;
    sum = 0;
    p   = 3;
    k   = 0;
    while (p <= (longint'(1) << ANG_Q)) begin
      t   = longint'(udiv(64'd1 << ANG_Q, p * longint'(2 * k + 1)));
      sum = (k % 2 == 1) ? sum - t : sum + t;
      p   = p * 9;
      k   = k + 1;
    end
    return sum;
  endfunction

  // step angle of cordic step i in degrees with frac fraction bits, rounded
  function automatic longint atan_deg(input int i, input int frac);
    longint unsigned quarter;
    longint unsigned n;
    longint unsigned q;
    longint unsigned r;
    if (i == 0) begin
      return longint'(45) << frac;
    end
    quarter = longint'(atan_pow2(1) + atan_third());
    n = longint'(atan_pow2(i)) * 45;
    q = udiv(n, quarter);
    r = n - q * quarter;
    for (int b = 0; b < frac; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= quarter) begin
        r    = r - quarter;
        q[0] = 1'b1;
      end
    end
    r = r << 1;
    if (r >= quarter) begin
      q = q + 1;
    end
    return longint'(q);
  endfunction

endpackage

@@ src/cht_cordic.sv @@
// cht_cordic: pipelined vectoring cordic, atan2 of (point - centre) in degrees
// depends on cht_pkg
module cht_cordic #(
  parameter int COORD_BITS   = cht_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS    = cht_pkg::DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = cht_pkg::DEF_CORDIC_STEPS
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [COORD_BITS-1:0]                      cx,
  input  logic [COORD_BITS-1:0]                      cy,
  input  logic [COORD_BITS-1:0]                      px,
  input  logic [COORD_BITS-1:0]                      py,
  output logic signed [FRAC_BITS+cht_pkg::INT_DEG_W-1:0] z_out,
  output logic                                       zero_out
);

  localparam int ZW       = FRAC_BITS + cht_pkg::INT_DEG_W;
  localparam int XW       = cht_pkg::XY_W;
  localparam int PRESHIFT = cht_pkg::ANG_Q - COORD_BITS;
  localparam logic signed [ZW-1:0] DEG90 = ZW'(longint'(90) << FRAC_BITS);

  logic signed [XW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  logic                 zero_r [0:CORDIC_STEPS];

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [XW-1:0]       xs;
  logic signed [XW-1:0]       ys;

  assign dx = $signed({1'b0, px}) - $signed({1'b0, cx});
  assign dy = $signed({1'b0, py}) - $signed({1'b0, cy});
  assign xs = XW'(dx) <<< PRESHIFT;
  assign ys = XW'(dy) <<< PRESHIFT;

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (dx == '0) && (dy == '0);
      if (xs < 0) begin
        if (ys >= 0) begin
          x_r[0] <= ys;
          y_r[0] <= -xs;
          z_r[0] <= DEG90;
        end else begin
          x_r[0] <= -ys;
          y_r[0] <= xs;
          z_r[0] <= -DEG90;
        end
      end else begin
        x_r[0] <= xs;
        y_r[0] <= ys;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(cht_pkg::atan_deg(i, FRAC_BITS));
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ANG;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ANG;
        end
      end
    end
  end

  assign z_out    = z_r[CORDIC_STEPS];
  assign zero_out = zero_r[CORDIC_STEPS];

endmodule

@@ src/clock_hands_to_time.sv @@
// clock_hands_to_time: one transaction per cycle while the output is not stalled;
// three parallel cordic pipelines set the depth
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset (rst_n, synchronous, active low) clears only the valid bits
// depends on cht_pkg and cht_cordic
module clock_hands_to_time #(
  parameter int COORD_BITS   = cht_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS    = cht_pkg::DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = cht_pkg::DEF_CORDIC_STEPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cht_pkg::IN_W-1:0]      in_center_x,
  input  logic [cht_pkg::IN_W-1:0]      in_center_y,
  input  logic [cht_pkg::IN_W-1:0]      in_marker_x,
  input  logic [cht_pkg::IN_W-1:0]      in_marker_y,
  input  logic [cht_pkg::IN_W-1:0]      in_minute_x,
  input  logic [cht_pkg::IN_W-1:0]      in_minute_y,
  input  logic [cht_pkg::IN_W-1:0]      in_hour_x,
  input  logic [cht_pkg::IN_W-1:0]      in_hour_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cht_pkg::HOUR_W-1:0]    out_hour_value,
  output logic [cht_pkg::MINUTE_W-1:0]  out_minute_value
);

  localparam int ZW = FRAC_BITS + cht_pkg::INT_DEG_W;
  // coordinate bits actually taken from the 12-bit ports
  localparam int UW = (COORD_BITS < cht_pkg::IN_W) ? COORD_BITS : cht_pkg::IN_W;
  localparam logic signed [ZW-1:0] DEG180 = ZW'(longint'(180) << FRAC_BITS);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(longint'(360) << FRAC_BITS);
  localparam logic signed [ZW-1:0] ONE_M1 = ZW'((longint'(1) << FRAC_BITS) - 1);

  // reciprocal multipliers: x/30 ~ x*137>>12 and x/6 ~ x*683>>12, exact for x < 256
  localparam int DEG_W = 8;
  localparam int RCP_SH = 12;
  localparam logic [7:0] RCP30 = 8'd137;
  localparam logic [9:0] RCP6  = 10'd683;

  // whole pipeline advances when the output register is free or drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // trimmed coordinates
  logic [COORD_BITS-1:0] cx, cy, tx, ty, mx, my, hx, hy;
  assign cx = COORD_BITS'(in_center_x[UW-1:0]);
  assign cy = COORD_BITS'(in_center_y[UW-1:0]);
  assign tx = COORD_BITS'(in_marker_x[UW-1:0]);
  assign ty = COORD_BITS'(in_marker_y[UW-1:0]);
  assign mx = COORD_BITS'(in_minute_x[UW-1:0]);
  assign my = COORD_BITS'(in_minute_y[UW-1:0]);
  assign hx = COORD_BITS'(in_hour_x[UW-1:0]);
  assign hy = COORD_BITS'(in_hour_y[UW-1:0]);

  logic signed [ZW-1:0] tz, mz, hz;
  logic                 t0, m0, h0;

  cht_cordic #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS),
               .CORDIC_STEPS(CORDIC_STEPS)) u_marker (
    .clk(clk), .en(en), .cx(cx), .cy(cy), .px(tx), .py(ty),
    .z_out(tz), .zero_out(t0));

  cht_cordic #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS),
               .CORDIC_STEPS(CORDIC_STEPS)) u_minute (
    .clk(clk), .en(en), .cx(cx), .cy(cy), .px(mx), .py(my),
    .z_out(mz), .zero_out(m0));

  cht_cordic #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS),
               .CORDIC_STEPS(CORDIC_STEPS)) u_hour (
    .clk(clk), .en(en), .cx(cx), .cy(cy), .px(hx), .py(hy),
    .z_out(hz), .zero_out(h0));

  // valid bits riding alongside the cordic stages
  logic vld_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= CORDIC_STEPS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // clamp each angle to the half turn, zero vector reads as zero
  function automatic logic signed [ZW-1:0] clamp_ang(input logic signed [ZW-1:0] z,
                                                     input logic zero);
    if (zero) return '0;
    if (z > DEG180) return DEG180;
    if (z < -DEG180) return -DEG180;
    return z;
  endfunction

  // stage a: hand angles relative to the marker
  logic                 a_vld_r;
  logic signed [ZW-1:0] a_m_r, a_h_r;
  logic signed [ZW-1:0] t_c;
  assign t_c = clamp_ang(tz, t0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_m_r <= clamp_ang(mz, m0) - t_c;
      a_h_r <= clamp_ang(hz, h0) - t_c;
    end
  end

  // stage b: one wrap into the half turn
  function automatic logic signed [ZW-1:0] wrap_ang(input logic signed [ZW-1:0] a);
    if (a < -DEG180) return a + DEG360;
    if (a > DEG180) return a - DEG360;
    return a;
  endfunction

  logic                 b_vld_r;
  logic signed [ZW-1:0] b_m_r, b_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_m_r <= wrap_ang(a_m_r);
      b_h_r <= wrap_ang(a_h_r);
    end
  end

  // stage c: whole degrees, floored for positive angles, ceiled and biased
  // for the rest, so a single reciprocal multiply finishes the bucket
  logic                   c_vld_r;
  logic                   c_mpos_r, c_hpos_r;
  logic [DEG_W-1:0]       c_mdeg_r, c_hdeg_r;
  logic signed [ZW-1:0]   m_neg_ceil, h_neg_ceil;

  assign m_neg_ceil = (-b_m_r + ONE_M1) >>> FRAC_BITS;
  assign h_neg_ceil = (-b_h_r + ONE_M1) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mpos_r <= (b_m_r > 0);
      c_hpos_r <= (b_h_r > 0);
      c_mdeg_r <= (b_m_r > 0) ? DEG_W'(b_m_r >>> FRAC_BITS)
                              : DEG_W'(m_neg_ceil + ZW'(5));
      c_hdeg_r <= (b_h_r > 0) ? DEG_W'(b_h_r >>> FRAC_BITS)
                              : DEG_W'(h_neg_ceil + ZW'(29));
    end
  end

  // output stage: bucket quotient and face mapping
  logic [DEG_W+7:0]  hq_full;
  logic [DEG_W+9:0]  mq_full;
  logic [cht_pkg::HOUR_W-1:0]   hq;
  logic [cht_pkg::MINUTE_W-1:0] mq;
  logic                 out_valid_r;
  logic [cht_pkg::HOUR_W-1:0]   hour_r;
  logic [cht_pkg::MINUTE_W-1:0] minute_r;

  assign hq_full = c_hdeg_r * RCP30;
  assign mq_full = c_mdeg_r * RCP6;
  assign hq      = cht_pkg::HOUR_W'(hq_full >> RCP_SH);
  assign mq      = cht_pkg::MINUTE_W'(mq_full >> RCP_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hour_r <= c_hpos_r ? hq : cht_pkg::HOUR_W'(12) - hq;
      if (c_mpos_r) begin
        minute_r <= mq;
      end else if (mq == '0) begin
        minute_r <= '0;   // sixty reads as zero
      end else begin
        minute_r <= cht_pkg::MINUTE_W'(60) - mq;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hour_value   = hour_r;
  assign out_minute_value = minute_r;

endmodule

@@ bench/clock_hands_to_time_test.sv @@
// clock_hands_to_time_test: self-checking bench for clock_hands_to_time with its own
// cordic reading predictor, random idling on both handshakes; depends on cht_pkg
// and the clock_hands_to_time rtl
module clock_hands_to_time_test;

  localparam int  IN_W      = cht_pkg::IN_W;
  localparam int  HOUR_W    = cht_pkg::HOUR_W;
  localparam int  MINUTE_W  = cht_pkg::MINUTE_W;
  localparam int  ANG_Q     = cht_pkg::ANG_Q;
  localparam int  COORD_MAX = 4095;
  localparam int  PRESHIFT  = ANG_Q - cht_pkg::DEF_COORD_BITS;
  localparam int  FRACB     = cht_pkg::DEF_FRAC_BITS;
  localparam int  STEPS     = cht_pkg::DEF_CORDIC_STEPS;
  localparam int  N_RANDOM  = 1350;
  localparam int  LIMIT     = 300000;
  localparam int  SETTLE    = 60;   // drain margin past the pipeline depth, with some slack

  typedef struct packed {
    logic [IN_W-1:0] cx, cy, mkx, mky, mnx, mny, hrx, hry;
  } reading_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } dial_time_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] in_center_x = '0, in_center_y = '0, in_marker_x = '0, in_marker_y = '0;
  logic [IN_W-1:0] in_minute_x = '0, in_minute_y = '0, in_hour_x = '0, in_hour_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [HOUR_W-1:0]   out_hour_value;
  logic [MINUTE_W-1:0] out_minute_value;

  clock_hands_to_time i_dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_center_x, .in_center_y, .in_marker_x, .in_marker_y,
    .in_minute_x, .in_minute_y, .in_hour_x, .in_hour_y,
    .out_valid, .out_ready, .out_hour_value, .out_minute_value
  );

  always #5 clk = ~clk;

  reading_t   readings_to_send[$];
  dial_time_t times_awaited[$];
  longint     rot_angle[STEPS];
  int         mismatches = 0;
  int         sent_count = 0;
  int         total_items = 0;
  int         cycle_count = 0;
  reading_t   cur;

  // ---------------------------------------------------------------------------
  // predictor: arctangent step table in degrees, built by integer series
  // ---------------------------------------------------------------------------
  function automatic longint atan_inv_pow2(int i);
    longint acc;
    int e;
    acc = 0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > ANG_Q) break;
      if (k % 2 == 1) acc -= (longint'(1) << (ANG_Q - e)) / (2 * k + 1);
      else            acc += (longint'(1) << (ANG_Q - e)) / (2 * k + 1);
    end
    return acc;
  endfunction

  function automatic longint atan_one_third();
    longint acc;
    longint p;
    int k;
    acc = 0;
    p = 3;
    k = 0;
    while (p <= (longint'(1) << ANG_Q)) begin
      if (k % 2 == 1) acc -= (longint'(1) << ANG_Q) / (p * (2 * k + 1));
      else            acc += (longint'(1) << ANG_Q) / (p * (2 * k + 1));
      p = p * 9;
      k++;
    end
    return acc;
  endfunction

  task automatic build_rotation_table();
    longint unsigned eighth, num, quo, rem;
    // pi/4 as the sum of atan(1/2) and atan(1/3), scaled to 45 degrees
    eighth = longint'(atan_inv_pow2(1) + atan_one_third());
    rot_angle[0] = longint'(45) << FRACB;
    for (int i = 1; i < STEPS; i++) begin
      num = longint'(atan_inv_pow2(i)) * 45;
      quo = num / eighth;
      rem = num % eighth;
      for (int b = 0; b < FRACB; b++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= eighth) begin
          rem = rem - eighth;
          quo = quo | 1;
        end
      end
      rem = rem << 1;
      if (rem >= eighth) quo = quo + 1;
      rot_angle[i] = longint'(quo);
    end
  endtask

  // vectoring cordic: angle of (dx, dy) in fixed point degrees, clamped
  function automatic longint vector_angle(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    longint half_turn;
    half_turn = longint'(180) << FRACB;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< PRESHIFT;
    y = dy <<< PRESHIFT;
    z = 0;
    // fold the left half plane onto the right one first
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(90) << FRACB;
      end else begin
        t = x; x = -y; y = t; z = -(longint'(90) << FRACB);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += rot_angle[i];
      end else begin
        x -= ys; y += xs; z -= rot_angle[i];
      end
    end
    if (z > half_turn)  z = half_turn;
    if (z < -half_turn) z = -half_turn;
    return z;
  endfunction

  function automatic longint wrap_half_turn(longint a);
    longint half_turn;
    half_turn = longint'(180) << FRACB;
    if (a < -half_turn) return a + 2 * half_turn;
    if (a > half_turn)  return a - 2 * half_turn;
    return a;
  endfunction

  function automatic dial_time_t read_dial(reading_t r);
    longint ref_ang, min_ang, hr_ang, hv, mv;
    longint per_hour, per_minute;
    dial_time_t res;
    per_hour   = longint'(30) << FRACB;
    per_minute = longint'(6) << FRACB;
    ref_ang = vector_angle(longint'(r.mkx) - longint'(r.cx), longint'(r.mky) - longint'(r.cy));
    min_ang = wrap_half_turn(vector_angle(longint'(r.mnx) - longint'(r.cx),
                                          longint'(r.mny) - longint'(r.cy)) - ref_ang);
    hr_ang  = wrap_half_turn(vector_angle(longint'(r.hrx) - longint'(r.cx),
                                          longint'(r.hry) - longint'(r.cy)) - ref_ang);
    if (hr_ang > 0) hv = hr_ang / per_hour;
    else            hv = 12 - ((-hr_ang + per_hour - 1) / per_hour);
    if (min_ang > 0) begin
      mv = min_ang / per_minute;
    end else begin
      mv = 60 - ((-min_ang + per_minute - 1) / per_minute);
      if (mv == 60) mv = 0;
    end
    res.hour   = hv[HOUR_W-1:0];
    res.minute = mv[MINUTE_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic reading_t mk(int cx, int cy, int ax, int ay, int bx, int by,
                                  int hx, int hy);
    reading_t r;
    r = '{IN_W'(cx), IN_W'(cy), IN_W'(ax), IN_W'(ay), IN_W'(bx), IN_W'(by),
          IN_W'(hx), IN_W'(hy)};
    return r;
  endfunction

  // point at a random offset around the centre, kept inside the pixel grid
  function automatic int near(int c, int span);
    int v;
    v = c + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // idling: phase 0 sender 18% / receiver 63%, phase 1 swapped, phase 2 none
  function automatic int idle_phase();
    if (sent_count < total_items / 3) return 0;
    if (sent_count < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  initial begin
    int cx, cy, span;
    build_rotation_table();

    // directed: zero vectors, grid extremes, quarter positions, half turn
    readings_to_send.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    readings_to_send.push_back(mk(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    readings_to_send.push_back(mk(0, 0, 4095, 4095, 4095, 0, 0, 4095));
    readings_to_send.push_back(mk(4095, 4095, 0, 0, 4095, 0, 0, 4095));
    readings_to_send.push_back(mk(2048, 2048, 2048, 0, 4095, 2048, 2048, 4095));
    readings_to_send.push_back(mk(2048, 2048, 2048, 0, 0, 2048, 2048, 0));
    readings_to_send.push_back(mk(2048, 2048, 2048, 0, 2048, 4095, 0, 2048));
    readings_to_send.push_back(mk(2048, 2048, 2048, 0, 2048, 2048, 2048, 2048));
    readings_to_send.push_back(mk(2048, 2048, 2048, 2048, 2049, 2047, 2047, 2047));
    readings_to_send.push_back(mk(100, 100, 0, 100, 200, 100, 100, 0));
    readings_to_send.push_back(mk(100, 100, 0, 100, 0, 99, 0, 101));
    readings_to_send.push_back(mk(100, 100, 100, 0, 101, 0, 99, 0));
    readings_to_send.push_back(mk(1000, 1000, 1000, 0, 2000, 0, 0, 2000));
    readings_to_send.push_back(mk(1000, 1000, 1000, 2000, 1000, 0, 2000, 1000));
    readings_to_send.push_back(mk(2048, 2048, 2048, 1048, 2548, 1182, 2914, 1548));
    readings_to_send.push_back(mk(2730, 1365, 2730, 2730, 1365, 1365, 4095, 0));
    readings_to_send.push_back(mk(0, 4095, 4095, 0, 0, 0, 4095, 4095));

    // random: mostly dial shaped readings, some raw noise
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(9))
        0, 1: begin
          readings_to_send.push_back(mk($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
            $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
            $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom_range(COORD_MAX)));
        end
        2: begin
          // tiny dial, hands often on the centre or on a boundary
          cx = $urandom_range(COORD_MAX);
          cy = $urandom_range(COORD_MAX);
          readings_to_send.push_back(mk(cx, cy, near(cx, 2), near(cy, 2), near(cx, 2),
                                        near(cy, 2), near(cx, 2), near(cy, 2)));
        end
        default: begin
          cx = $urandom_range(COORD_MAX);
          cy = $urandom_range(COORD_MAX);
          span = $urandom_range(2047, 1);
          readings_to_send.push_back(mk(cx, cy, near(cx, span), near(cy, span),
                                        near(cx, span), near(cy, span), near(cx, span),
                                        near(cy, span)));
        end
      endcase
    end
    total_items = readings_to_send.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all transactions sent and every reading returned
    do @(posedge clk);
    while (readings_to_send.size() != 0 || in_valid || times_awaited.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && times_awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: holds a transaction until accepted, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        times_awaited.push_back(read_dial(cur));
        sent_count++;
      end
      if (in_valid && !fire) begin
        // keep holding the same transaction
      end else if (readings_to_send.size() != 0 &&
                   $urandom_range(99) >= (idle_phase() == 0 ? 18 :
                                          idle_phase() == 1 ? 63 : 0)) begin
        cur = readings_to_send.pop_front();
        in_valid    <= 1'b1;
        in_center_x <= cur.cx;
        in_center_y <= cur.cy;
        in_marker_x <= cur.mkx;
        in_marker_y <= cur.mky;
        in_minute_x <= cur.mnx;
        in_minute_y <= cur.mny;
        in_hour_x   <= cur.hrx;
        in_hour_y   <= cur.hry;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back pressure, compares each reading with the oldest one awaited
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dial_time_t want;
    if (rst_n && out_valid && out_ready) begin
      if (times_awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: hour %0d minute %0d",
                   out_hour_value, out_minute_value);
      end else begin
        want = times_awaited.pop_front();
        if (want.hour !== out_hour_value || want.minute !== out_minute_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hour %0d minute %0d, got hour %0d minute %0d",
                     want.hour, want.minute, out_hour_value, out_minute_value);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= (idle_phase() == 0 ? 63 :
                                         idle_phase() == 1 ? 18 : 0));
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
